// ----- hw/rtl/glyph_text_rect_expander_core_assert.svh -----
// Assertion macros shared by the expander RTL files.
// No dependencies; included inside module bodies.
`ifndef GLYPH_TEXT_RECT_EXPANDER_CORE_ASSERT_SVH
`define GLYPH_TEXT_RECT_EXPANDER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define GTRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define GTRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/gtre_pkg.sv -----
// Shared types, constants and font table for the glyph text rectangle expander.
// No dependencies.
package gtre_pkg;
    localparam int MaxDimDef     = 4096;
    localparam int CursorBitsDef = 16;
    localparam int MaxScaleDef   = 255;
    localparam int QDepth        = 4;

    localparam logic [2:0] RegEnable = 3'd0;
    localparam logic [2:0] RegWidth  = 3'd1;
    localparam logic [2:0] RegHeight = 3'd2;
    localparam logic [2:0] RegRed    = 3'd3;
    localparam logic [2:0] RegGreen  = 3'd4;
    localparam logic [2:0] RegBlue   = 3'd5;
    localparam logic [2:0] RegColour = 3'd6;
    localparam logic [2:0] RegScale  = 3'd7;

    localparam logic [7:0] ChNewline = 8'd10;

    // One 5x7 glyph, row 0 in bits 4:0, each row MSB leftmost.
    function automatic logic [34:0] glyph_rows(input logic [7:0] ch);
        logic [7:0] c;
        logic [34:0] g;
        c = ch;
        if (c >= 8'h61 && c <= 8'h7a) c = c - 8'h20;
        case (c)
            8'h30: g = {5'd14,5'd17,5'd25,5'd21,5'd19,5'd17,5'd14};
            8'h31: g = {5'd14,5'd4,5'd4,5'd4,5'd4,5'd12,5'd4};
            8'h32: g = {5'd31,5'd8,5'd4,5'd2,5'd1,5'd17,5'd14};
            8'h33: g = {5'd30,5'd1,5'd1,5'd14,5'd1,5'd1,5'd30};
            8'h34: g = {5'd2,5'd2,5'd31,5'd18,5'd10,5'd6,5'd2};
            8'h35: g = {5'd30,5'd1,5'd1,5'd30,5'd16,5'd16,5'd31};
            8'h36: g = {5'd14,5'd17,5'd17,5'd30,5'd16,5'd8,5'd6};
            8'h37: g = {5'd8,5'd8,5'd8,5'd4,5'd2,5'd1,5'd31};
            8'h38: g = {5'd14,5'd17,5'd17,5'd14,5'd17,5'd17,5'd14};
            8'h39: g = {5'd12,5'd2,5'd1,5'd15,5'd17,5'd17,5'd14};
            8'h41: g = {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd14};
            8'h42: g = {5'd30,5'd17,5'd17,5'd30,5'd17,5'd17,5'd30};
            8'h43: g = {5'd14,5'd17,5'd16,5'd16,5'd16,5'd17,5'd14};
            8'h44: g = {5'd30,5'd17,5'd17,5'd17,5'd17,5'd17,5'd30};
            8'h45: g = {5'd31,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
            8'h46: g = {5'd16,5'd16,5'd16,5'd30,5'd16,5'd16,5'd31};
            8'h47: g = {5'd15,5'd17,5'd17,5'd23,5'd16,5'd17,5'd14};
            8'h48: g = {5'd17,5'd17,5'd17,5'd31,5'd17,5'd17,5'd17};
            8'h49: g = {5'd14,5'd4,5'd4,5'd4,5'd4,5'd4,5'd14};
            8'h4a: g = {5'd12,5'd18,5'd18,5'd2,5'd2,5'd2,5'd7};
            8'h4b: g = {5'd17,5'd18,5'd20,5'd24,5'd20,5'd18,5'd17};
            8'h4c: g = {5'd31,5'd16,5'd16,5'd16,5'd16,5'd16,5'd16};
            8'h4d: g = {5'd17,5'd17,5'd17,5'd21,5'd21,5'd27,5'd17};
            8'h4e: g = {5'd17,5'd17,5'd17,5'd19,5'd21,5'd25,5'd17};
            8'h4f: g = {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd14};
            8'h50: g = {5'd16,5'd16,5'd16,5'd30,5'd17,5'd17,5'd30};
            8'h51: g = {5'd13,5'd18,5'd21,5'd17,5'd17,5'd17,5'd14};
            8'h52: g = {5'd17,5'd18,5'd20,5'd30,5'd17,5'd17,5'd30};
            8'h53: g = {5'd30,5'd1,5'd1,5'd14,5'd16,5'd16,5'd15};
            8'h54: g = {5'd4,5'd4,5'd4,5'd4,5'd4,5'd4,5'd31};
            8'h55: g = {5'd14,5'd17,5'd17,5'd17,5'd17,5'd17,5'd17};
            8'h56: g = {5'd4,5'd10,5'd17,5'd17,5'd17,5'd17,5'd17};
            8'h57: g = {5'd17,5'd27,5'd21,5'd21,5'd17,5'd17,5'd17};
            8'h58: g = {5'd17,5'd17,5'd10,5'd4,5'd10,5'd17,5'd17};
            8'h59: g = {5'd4,5'd4,5'd4,5'd4,5'd10,5'd17,5'd17};
            8'h5a: g = {5'd31,5'd16,5'd8,5'd4,5'd2,5'd1,5'd31};
            8'h3a: g = {5'd0,5'd4,5'd0,5'd0,5'd4,5'd0,5'd0};
            8'h3e: g = {5'd0,5'd0,5'd16,5'd8,5'd16,5'd0,5'd0};
            8'h2f: g = {5'd0,5'd4,5'd4,5'd0,5'd4,5'd4,5'd0};
            8'h20: g = '0;
            default: g = {5'd0,5'd0,5'd0,5'd31,5'd0,5'd0,5'd0};
        endcase
        return g;
    endfunction

    // One classified character handed from the front to the back.
    typedef struct packed {
        logic [34:0] cells;
        logic [15:0] base_x;
        logic [15:0] base_y;
    } t_job;
endpackage

// ----- hw/rtl/glyph_text_rect_expander_core.sv -----
// Top level of the glyph text rectangle expander: registers, front, queue, back.
// Depends on gtre_pkg, gtre_front, gtre_queue and gtre_back.
//
// Characters are accepted at the input whenever the queue has room. In the back end a
// drawn character is loaded from the queue, its 35 glyph cells are visited in turn
// by the cell walker, which emits at most one rectangle per cycle, and then the final
// rectangle, if any cell survived clipping, is flushed. A four-entry queue lets
// characters be taken while earlier glyphs are still being drawn.
module glyph_text_rect_expander_core #(
    parameter int MaxDim     = gtre_pkg::MaxDimDef,
    parameter int CursorBits = gtre_pkg::CursorBitsDef,
    parameter int MaxScale   = gtre_pkg::MaxScaleDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // char_code, start_x, start_y
    input  logic        s_axis_tuser,  // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // rect_x, rect_y, rect_w, rect_h, pixel_value
    output logic        m_axis_tlast,  // last
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import gtre_pkg::*;

    logic r_enable;
    logic [12:0] r_sw, r_sh;
    logic [4:0] r_rs, r_gs, r_bs;
    logic [23:0] r_col;
    logic [7:0] r_scale;
    logic [31:0] pix;
    logic jv, jr, qv, qpop;
    t_job job, qjob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_sw <= '0;
            r_sh <= '0;
            r_rs <= 5'd16;
            r_gs <= 5'd8;
            r_bs <= 5'd0;
            r_col <= '0;
            r_scale <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegEnable: r_enable <= i_cfg_data[0];
                RegWidth:  r_sw <= i_cfg_data[12:0];
                RegHeight: r_sh <= i_cfg_data[12:0];
                RegRed:    r_rs <= i_cfg_data[4:0];
                RegGreen:  r_gs <= i_cfg_data[4:0];
                RegBlue:   r_bs <= i_cfg_data[4:0];
                RegColour: r_col <= i_cfg_data;
                RegScale:  r_scale <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign pix = (32'(r_col[23:16]) << r_rs) | (32'(r_col[15:8]) << r_gs) |
                 (32'(r_col[7:0]) << r_bs);

    gtre_front #(.CursorBits(CursorBits), .MaxScale(MaxScale)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_char_code(s_axis_tdata[7:0]), .i_first(s_axis_tuser),
        .i_start_x(s_axis_tdata[23:8]), .i_start_y(s_axis_tdata[39:24]),
        .i_enable(r_enable), .i_scale(r_scale),
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    gtre_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(jv), .o_not_full(jr), .i_data(job),
        .o_valid(qv), .i_pop(qpop), .o_data(qjob)
    );

    gtre_back #(.MaxDim(MaxDim), .MaxScale(MaxScale)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(qv), .o_job_pop(qpop), .i_job(qjob),
        .i_screen_width(r_sw), .i_screen_height(r_sh), .i_scale(r_scale),
        .i_pixel(pix),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_rect_x(m_axis_tdata[11:0]), .o_rect_y(m_axis_tdata[23:12]),
        .o_rect_w(m_axis_tdata[31:24]), .o_rect_h(m_axis_tdata[39:32]),
        .o_pixel(m_axis_tdata[71:40]), .o_last(m_axis_tlast)
    );
endmodule

// ----- hw/rtl/gtre_front.sv -----
// Front end: accepts characters, keeps the cursor, looks up glyphs.
// Depends on gtre_pkg.
module gtre_front #(
    parameter int CursorBits = gtre_pkg::CursorBitsDef,
    parameter int MaxScale   = gtre_pkg::MaxScaleDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_char_code,
    input  logic              i_first,
    input  logic [15:0]       i_start_x,
    input  logic [15:0]       i_start_y,
    input  logic              i_enable,
    input  logic [7:0]        i_scale,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output gtre_pkg::t_job    o_job
);
    import gtre_pkg::*;
    localparam logic [CursorBits:0] CurMax = {1'b0, {CursorBits{1'b1}}};
    localparam int SclW = $clog2(MaxScale + 1);

    logic [CursorBits-1:0] r_cx, r_cy, n_cx, n_cy, lx, ly;
    logic [CursorBits:0] sum;
    logic [SclW-1:0] scl;
    logic [SclW+3:0] step;
    logic draw, acc;
    t_job job;

    always_comb begin
        lx = r_cx;
        ly = r_cy;
        if (i_first) begin
            lx = (CursorBits >= 16 || {16'(0), i_start_x} <= 32'(CurMax)) ?
                 CursorBits'(i_start_x) : CurMax[CursorBits-1:0];
            ly = (CursorBits >= 16 || {16'(0), i_start_y} <= 32'(CurMax)) ?
                 CursorBits'(i_start_y) : CurMax[CursorBits-1:0];
        end
        scl = (32'(i_scale) > 32'(MaxScale)) ? SclW'(MaxScale) : SclW'(i_scale);
        draw = (i_char_code != 8'd0) && i_enable && (i_scale != 8'd0);
        n_cx = lx;
        n_cy = ly;
        step = (SclW+4)'(scl) * (SclW+4)'(6);
        sum = '0;
        if (draw && i_char_code == ChNewline) begin
            step = (SclW+4)'(scl) << 3;
            sum = (CursorBits+1)'(ly) + (CursorBits+1)'(step);
            n_cy = (sum > CurMax) ? CurMax[CursorBits-1:0] : sum[CursorBits-1:0];
            n_cx = '0;
        end else if (draw) begin
            sum = (CursorBits+1)'(lx) + (CursorBits+1)'(step);
            n_cx = (sum > CurMax) ? CurMax[CursorBits-1:0] : sum[CursorBits-1:0];
        end
        job.cells = glyph_rows(i_char_code);
        job.base_x = (CursorBits > 16 && (|(lx >> 16))) ? 16'hffff : 16'(lx);
        job.base_y = (CursorBits > 16 && (|(ly >> 16))) ? 16'hffff : 16'(ly);
    end

    // Only drawable characters are queued; all wait for queue room.
    assign o_ready = i_job_ready;
    assign acc = i_valid && o_ready;
    assign o_job_valid = i_valid && draw && (i_char_code != ChNewline);
    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (acc) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end
endmodule

// ----- hw/rtl/gtre_queue.sv -----
// Short FIFO of classified jobs between front and back.
// Depends on gtre_pkg.
module gtre_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_not_full,
    input  gtre_pkg::t_job i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output gtre_pkg::t_job o_data
);
    import gtre_pkg::*;
    localparam int AW = $clog2(QDepth);
    t_job r_mem [QDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign o_not_full = r_cnt != (AW+1)'(QDepth);
    assign o_valid = r_cnt != '0;
    assign o_data = r_mem[r_rp];
    assign push = i_push && o_not_full;
    assign pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + AW'(1);
            if (pop) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `include "glyph_text_rect_expander_core_assert.svh"
    `GTRE_ASSERT_IMP(a_q_bound, 1'b1, r_cnt <= (AW+1)'(QDepth))
    `GTRE_ASSERT_NEXT(a_q_fill, push && !pop, r_cnt == $past(r_cnt) + (AW+1)'(1))
    `GTRE_ASSERT_NEXT(a_q_drain, pop && !push, r_cnt == $past(r_cnt) - (AW+1)'(1))
endmodule

// ----- hw/rtl/gtre_back.sv -----
// Back end: walks the 35 cells of a job, clips and emits rectangles.
// Depends on gtre_pkg.
module gtre_back #(
    parameter int MaxDim   = gtre_pkg::MaxDimDef,
    parameter int MaxScale = gtre_pkg::MaxScaleDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_pop,
    input  gtre_pkg::t_job i_job,
    input  logic [12:0]    i_screen_width,
    input  logic [12:0]    i_screen_height,
    input  logic [7:0]     i_scale,
    input  logic [31:0]    i_pixel,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [11:0]    o_rect_x,
    output logic [11:0]    o_rect_y,
    output logic [7:0]     o_rect_w,
    output logic [7:0]     o_rect_h,
    output logic [31:0]    o_pixel,
    output logic           o_last
);
    import gtre_pkg::*;
    localparam int SclW = $clog2(MaxScale + 1);
    localparam int PW = 20;

    logic r_busy, r_pend;
    logic [5:0] r_idx;
    logic [2:0] r_row, r_col;
    logic [PW-1:0] r_px, r_py;
    t_job r_job;
    logic [12:0] bw, bh;
    logic [SclW-1:0] scl;
    logic [5:0] cbit;
    logic hit, keep, last_cell, adv, emit_mid, emit_end;
    logic [PW-1:0] dx, dy, w, h;
    logic r_hv;
    logic [11:0] r_hx, r_hy;
    logic [7:0] r_hw, r_hh;

    always_comb begin
        bw = (32'(i_screen_width) > 32'(MaxDim)) ? 13'(MaxDim) : i_screen_width;
        bh = (32'(i_screen_height) > 32'(MaxDim)) ? 13'(MaxDim) : i_screen_height;
        scl = (32'(i_scale) > 32'(MaxScale)) ? SclW'(MaxScale) : SclW'(i_scale);
        cbit = 6'd5 * 6'(r_row) + 6'd4 - 6'(r_col);
        hit = r_job.cells[cbit];
        keep = hit && r_px < PW'(bw) && r_py < PW'(bh);
        dx = PW'(bw) - r_px;
        dy = PW'(bh) - r_py;
        w = (PW'(scl) > dx) ? dx : PW'(scl);
        h = (PW'(scl) > dy) ? dy : PW'(scl);
        last_cell = r_idx == 6'd34;
    end

    // Output stage: a held rectangle (r_hv) waits until the next kept one is known
    // or the job ends, so that last can be set on the final one.
    assign adv = r_busy && (!r_hv || !keep || !o_valid || i_ready);
    assign o_job_pop = !r_busy && !r_pend && i_job_valid;
    assign emit_mid = adv && keep && r_hv;
    assign emit_end = !r_busy && r_pend && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_hv <= 1'b0;
            o_valid <= 1'b0;
            o_last <= 1'b0;
        end else begin
            if (emit_mid || emit_end) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (o_job_pop) begin
                r_job <= i_job;
                r_busy <= 1'b1;
                r_idx <= '0;
                r_row <= '0;
                r_col <= '0;
                r_px <= PW'(i_job.base_x);
                r_py <= PW'(i_job.base_y);
            end else if (adv) begin
                if (keep) begin
                    if (r_hv) begin
                        o_last <= 1'b0;
                        o_rect_x <= r_hx;
                        o_rect_y <= r_hy;
                        o_rect_w <= r_hw;
                        o_rect_h <= r_hh;
                        o_pixel <= i_pixel;
                    end
                    r_hv <= 1'b1;
                    r_hx <= r_px[11:0];
                    r_hy <= r_py[11:0];
                    r_hw <= w[7:0];
                    r_hh <= h[7:0];
                end
                r_idx <= r_idx + 6'd1;
                if (r_col == 3'd4) begin
                    r_col <= '0;
                    r_row <= r_row + 3'd1;
                    r_px <= PW'(r_job.base_x);
                    r_py <= r_py + PW'(scl);
                end else begin
                    r_col <= r_col + 3'd1;
                    r_px <= r_px + PW'(scl);
                end
                if (last_cell) begin
                    r_busy <= 1'b0;
                    r_pend <= r_hv || keep;
                end
            end else if (emit_end) begin
                o_last <= 1'b1;
                o_rect_x <= r_hx;
                o_rect_y <= r_hy;
                o_rect_w <= r_hw;
                o_rect_h <= r_hh;
                o_pixel <= i_pixel;
                r_hv <= 1'b0;
                r_pend <= 1'b0;
            end
        end
    end

    `include "glyph_text_rect_expander_core_assert.svh"
    `GTRE_ASSERT_IMP(a_b_nopop, r_busy || r_pend, !o_job_pop)
    `GTRE_ASSERT_IMP(a_b_pend, r_pend, r_hv && !r_busy)
endmodule

// ----- tb/glyph_text_rect_expander_core_tb.sv -----
// Self-checking testbench for glyph_text_rect_expander_core: characters are streamed in,
// each expected fill rectangle is predicted on acceptance and compared with the output stream.
// Depends on gtre_pkg and the expander RTL.
module glyph_text_rect_expander_core_tb;
    import gtre_pkg::*;

    localparam int CursorMax = 65535;
    localparam int SettleCycles = 200;
    localparam int WatchLimit = 5000;

    typedef struct {
        logic [7:0]  ch;
        logic        first;
        logic [15:0] sx;
        logic [15:0] sy;
    } t_glyph_item;

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [31:0] pix;
        logic        last;
    } t_rect;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // char_code, start_x, start_y
    logic        s_axis_tuser = 1'b0;  // first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;  // rect_x, rect_y, rect_w, rect_h, pixel_value
    logic        m_axis_tlast;  // last
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = RegEnable;
    logic [23:0] i_cfg_data = '0;

    glyph_text_rect_expander_core u_top (.*);

    always #5 i_clk = ~i_clk;

    // Shadow registers and cursor.
    logic        sh_enable;
    logic [12:0] sh_width, sh_height;
    logic [4:0]  sh_rs, sh_gs, sh_bs;
    logic [23:0] sh_colour;
    logic [7:0]  sh_scale;
    int          cur_x, cur_y;

    t_glyph_item char_pending_q[$];
    t_rect       rect_expect_q[$];
    t_glyph_item tx_item;
    bit          tx_busy = 0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          hold_cnt = 0;
    bit          hold_go = 0, hold_done = 0;
    bit          no_idle = 0;
    int          errors = 0;
    int          quiet = 0;

    byte digit_font[10][7] = '{
        '{14,17,19,21,25,17,14}, '{4,12,4,4,4,4,14}, '{14,17,1,2,4,8,31},
        '{30,1,1,14,1,1,30}, '{2,6,10,18,31,2,2}, '{31,16,16,30,1,1,30},
        '{6,8,16,30,17,17,14}, '{31,1,2,4,8,8,8}, '{14,17,17,14,17,17,14},
        '{14,17,17,15,1,2,12}};
    byte alpha_font[26][7] = '{
        '{14,17,17,31,17,17,17}, '{30,17,17,30,17,17,30}, '{14,17,16,16,16,17,14},
        '{30,17,17,17,17,17,30}, '{31,16,16,30,16,16,31}, '{31,16,16,30,16,16,16},
        '{14,17,16,23,17,17,15}, '{17,17,17,31,17,17,17}, '{14,4,4,4,4,4,14},
        '{7,2,2,2,18,18,12}, '{17,18,20,24,20,18,17}, '{16,16,16,16,16,16,31},
        '{17,27,21,21,17,17,17}, '{17,25,21,19,17,17,17}, '{14,17,17,17,17,17,14},
        '{30,17,17,30,16,16,16}, '{14,17,17,17,21,18,13}, '{30,17,17,30,20,18,17},
        '{15,16,16,14,1,1,30}, '{31,4,4,4,4,4,4}, '{17,17,17,17,17,17,14},
        '{17,17,17,17,17,10,4}, '{17,17,17,21,21,27,17}, '{17,17,10,4,10,17,17},
        '{17,17,10,4,4,4,4}, '{31,1,2,4,8,16,31}};

    function automatic logic [4:0] font_row(logic [7:0] ch, int r);
        logic [7:0] c;
        c = ch;
        if (c >= "0" && c <= "9") return 5'(digit_font[c - "0"][r]);
        if (c >= "a" && c <= "z") c = c - 8'h20;
        if (c >= "A" && c <= "Z") return 5'(alpha_font[c - "A"][r]);
        if (c == "-") return (r == 3) ? 5'd31 : 5'd0;
        if (c == ":") return (r == 2 || r == 5) ? 5'd4 : 5'd0;
        if (c == ">") return (r == 2 || r == 4) ? 5'd16 : ((r == 3) ? 5'd8 : 5'd0);
        if (c == "/") return (r == 1 || r == 2 || r == 4 || r == 5) ? 5'd4 : 5'd0;
        if (c == " ") return 5'd0;
        return (r == 3) ? 5'd31 : 5'd0;
    endfunction

    function automatic int sat_cursor(int v);
        return (v > CursorMax) ? CursorMax : v;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [23:0] v);
        case (idx)
            RegEnable: sh_enable = v[0];
            RegWidth:  sh_width = v[12:0];
            RegHeight: sh_height = v[12:0];
            RegRed:    sh_rs = v[4:0];
            RegGreen:  sh_gs = v[4:0];
            RegBlue:   sh_bs = v[4:0];
            RegColour: sh_colour = v;
            RegScale:  sh_scale = v[7:0];
            default: ;
        endcase
    endfunction

    function automatic void expand_glyph(t_glyph_item it);
        int sc, bw, bh, px, py, n;
        logic [4:0] bits;
        logic [63:0] p;
        t_rect rr;
        if (it.first) begin
            cur_x = it.sx;
            cur_y = it.sy;
        end
        if (it.ch == 8'd0 || !sh_enable || sh_scale == 8'd0) return;
        sc = sh_scale;
        if (it.ch == ChNewline) begin
            cur_y = sat_cursor(cur_y + 8 * sc);
            cur_x = 0;
            return;
        end
        bw = (sh_width > MaxDimDef) ? MaxDimDef : sh_width;
        bh = (sh_height > MaxDimDef) ? MaxDimDef : sh_height;
        p = (64'(sh_colour[23:16]) << sh_rs) | (64'(sh_colour[15:8]) << sh_gs) |
            (64'(sh_colour[7:0]) << sh_bs);
        n = 0;
        for (int r = 0; r < 7; r++) begin
            bits = font_row(it.ch, r);
            for (int c = 0; c < 5; c++) begin
                px = cur_x + c * sc;
                py = cur_y + r * sc;
                if (bits[4-c] && px < bw && py < bh) begin
                    rr.x = px[11:0];
                    rr.y = py[11:0];
                    rr.w = (sc > bw - px) ? 8'(bw - px) : 8'(sc);
                    rr.h = (sc > bh - py) ? 8'(bh - py) : 8'(sc);
                    rr.pix = p[31:0];
                    rr.last = 1'b0;
                    rect_expect_q.push_back(rr);
                    n++;
                end
            end
        end
        if (n > 0) rect_expect_q[rect_expect_q.size()-1].last = 1'b1;
        cur_x = sat_cursor(cur_x + 6 * sc);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Sender.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expand_glyph(tx_item);
                tx_busy = 0;
                tx_gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (!tx_busy && tx_gap == 0 && char_pending_q.size() > 0) begin
                tx_item = char_pending_q.pop_front();
                tx_busy = 1;
            end else if (!tx_busy && tx_gap > 0) begin
                tx_gap--;
            end
            s_axis_tvalid <= tx_busy;
            s_axis_tdata <= {tx_item.sy, tx_item.sx, tx_item.ch};
            s_axis_tuser <= tx_item.first;
        end
    end

    // Receiver and checker.
    always @(posedge i_clk) begin
        t_rect e;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (rect_expect_q.size() == 0) begin
                    report_mismatch("rectangle with nothing expected");
                end else begin
                    e = rect_expect_q.pop_front();
                    if (m_axis_tdata[11:0] !== e.x)
                        report_mismatch($sformatf("rect_x %0d exp %0d", m_axis_tdata[11:0], e.x));
                    if (m_axis_tdata[23:12] !== e.y)
                        report_mismatch($sformatf("rect_y %0d exp %0d", m_axis_tdata[23:12], e.y));
                    if (m_axis_tdata[31:24] !== e.w)
                        report_mismatch($sformatf("rect_w %0d exp %0d", m_axis_tdata[31:24], e.w));
                    if (m_axis_tdata[39:32] !== e.h)
                        report_mismatch($sformatf("rect_h %0d exp %0d", m_axis_tdata[39:32], e.h));
                    if (m_axis_tdata[71:40] !== e.pix)
                        report_mismatch($sformatf("pixel %h exp %h", m_axis_tdata[71:40], e.pix));
                    if (m_axis_tlast !== e.last)
                        report_mismatch($sformatf("last %b exp %b", m_axis_tlast, e.last));
                end
                rx_gap = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (hold_go && !hold_done) begin
                hold_cnt = 600;
                hold_done = 1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any handshake or register write.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        apply_reg(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_char(logic [7:0] ch, logic first, logic [15:0] sx, logic [15:0] sy);
        t_glyph_item it;
        it.ch = ch;
        it.first = first;
        it.sx = sx;
        it.sy = sy;
        char_pending_q.push_back(it);
    endtask

    task automatic drain;
        while (char_pending_q.size() > 0 || tx_busy || rect_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic setup_regs(logic en, logic [23:0] w, logic [23:0] h, logic [23:0] sc);
        write_reg(RegEnable, {23'($urandom), en});
        write_reg(RegWidth, w);
        write_reg(RegHeight, h);
        write_reg(RegRed, 24'($urandom));
        write_reg(RegGreen, 24'($urandom));
        write_reg(RegBlue, 24'($urandom));
        write_reg(RegColour, 24'($urandom));
        write_reg(RegScale, sc);
    endtask

    function automatic logic [7:0] pick_char();
        string set;
        set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-:>/ ";
        case ($urandom_range(0, 19)) inside
            0: return ChNewline;
            1, 2: return 8'($urandom);
            default: return set[$urandom_range(0, set.len() - 1)];
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [15:0] sx, sy;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                sx = 16'($urandom);
                sy = 16'($urandom);
            end else begin
                sx = 16'($urandom_range(0, 400));
                sy = 16'($urandom_range(0, 300));
            end
            push_char(pick_char(), $urandom_range(0, 7) == 0, sx, sy);
        end
        drain();
    endtask

    initial begin
        string glyph_set;
        glyph_set = "9AZaz-:>/ ";
        sh_enable = 0; sh_width = 0; sh_height = 0;
        sh_rs = 16; sh_gs = 8; sh_bs = 0; sh_colour = 0; sh_scale = 1;
        cur_x = 0; cur_y = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every glyph kind, code zero, newline and unknown codes at scale one.
        setup_regs(1'b1, 24'd4096, 24'd4096, 24'd1);
        write_reg(RegRed, 24'd31);
        write_reg(RegColour, 24'hFFFFFF);
        push_char("0", 1'b1, 16'd0, 16'd0);
        foreach (glyph_set[k]) push_char(glyph_set[k], 1'b0, 16'd0, 16'd0);
        push_char(8'h00, 1'b0, 16'd0, 16'd0);
        push_char(ChNewline, 1'b0, 16'd0, 16'd0);
        push_char(8'h80, 1'b0, 16'd0, 16'd0);
        push_char(8'hFF, 1'b0, 16'd0, 16'd0);
        push_char("#", 1'b0, 16'd0, 16'd0);
        // Clipping at the right and bottom edges, fully clipped characters, cursor saturation.
        push_char("8", 1'b1, 16'd4093, 16'd4092);
        push_char("M", 1'b1, 16'd4094, 16'd100);
        push_char("W", 1'b0, 16'd0, 16'd0);
        push_char("H", 1'b1, 16'd65535, 16'd65535);
        push_char(ChNewline, 1'b0, 16'd0, 16'd0);
        push_char("B", 1'b1, 16'd65534, 16'd0);
        drain();

        // Disabled display and zero scale still load the cursor.
        setup_regs(1'b0, 24'd640, 24'd480, 24'd2);
        push_char("A", 1'b1, 16'd10, 16'd20);
        push_char(ChNewline, 1'b0, 16'd0, 16'd0);
        drain();
        write_reg(RegEnable, 24'd1);
        write_reg(RegScale, 24'd0);
        push_char("B", 1'b1, 16'd30, 16'd40);
        drain();
        write_reg(RegScale, 24'd2);
        push_char("C", 1'b0, 16'd0, 16'd0);
        drain();

        // Largest scale with oversized and zero screen registers.
        setup_regs(1'b1, 24'hFFFFFF, 24'd8191, 24'd255);
        push_char("8", 1'b1, 16'd0, 16'd0);
        push_char("W", 1'b0, 16'd0, 16'd0);
        push_char(ChNewline, 1'b0, 16'd0, 16'd0);
        push_char("0", 1'b0, 16'd0, 16'd0);
        drain();
        setup_regs(1'b1, 24'd0, 24'd0, 24'd3);
        push_char("8", 1'b1, 16'd0, 16'd0);
        drain();

        // Long receiver stall while the sender keeps offering items.
        setup_regs(1'b1, 24'd640, 24'd480, 24'd1);
        hold_go = 1;
        random_phase(40);

        for (int p = 0; p < 10; p++) begin
            no_idle = (p == 2 || p == 7);
            case (p)
                3: setup_regs(1'b0, 24'd640, 24'd480, 24'd2);
                5: setup_regs(1'b1, 24'($urandom), 24'($urandom), {16'($urandom), 8'd0});
                6: setup_regs(1'b1, 24'd4096, 24'd4096, 24'd255);
                8: setup_regs(1'b1, 24'd320, 24'd240, 24'($urandom_range(0, 40)));
                default: setup_regs(1'b1, 24'($urandom_range(100, 700)),
                                    24'($urandom_range(100, 500)),
                                    24'($urandom_range(1, 4)));
            endcase
            random_phase((p == 6) ? 8 : 42);
        end
        no_idle = 0;

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
